// ----- src/mi3_pkg.sv -----
// Package with widths, stage types and constants of the 3x3 matrix inverse pipeline.
package mi3_pkg;

   localparam int EW       = 16;
   localparam int OW       = 32;
   localparam int NE       = 9;
   localparam int FRAC_IN  = EW / 2;
   localparam int FRAC_OUT = OW / 2;
   localparam int SHIFT    = FRAC_IN + FRAC_OUT;
   localparam int UP       = FRAC_OUT - FRAC_IN;
   localparam int PW       = 2 * EW;
   localparam int CW       = 2 * EW + 1;
   localparam int TW       = 3 * EW + 1;
   localparam int DW       = 3 * EW + 3;
   localparam int NW       = PW + SHIFT;
   localparam int RW       = DW + OW;
   localparam int NS       = OW + 7;

   typedef logic signed [EW-1:0] elem_type;
   typedef logic signed [OW-1:0] res_type;

   typedef struct packed {
      logic [NW-1:0] rem;
      logic [OW-1:0] q;
      logic          negq;
      logic          ovf;
   } lane_type;

   typedef struct packed {
      lane_type [NE-1:0] lane;
      logic [DW-1:0]     dmag;
      logic              zero;
      elem_type [NE-1:0] a;
   } div_type;

endpackage

// ----- src/matrix_inverse_3x3.sv -----
// Top level of the pipelined 3x3 matrix inverse by the adjugate.
//
//   channel | ports                    | direction | beat
//   --------+--------------------------+-----------+------------------------
//   req     | req_valid/stall, m00-m22 | in        | one Q8.8 matrix
//   rsp     | rsp_valid/stall, r00-r22 | out       | Q16.16 inverse, singular
//
// One beat enters per cycle unless req_stall is high. The pipeline holds six front
// stages, the 32 stages of the restoring divider, one quotient bit per stage,
// and the output register. Reset clears only the stage valid bits. A stall
// holds the stages that have a valid beat behind it, while empty stages
// further up keep filling, so no beat is lost or repeated.
module matrix_inverse_3x3 (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mi3_pkg::elem_type req_m00,
   input  mi3_pkg::elem_type req_m01,
   input  mi3_pkg::elem_type req_m02,
   input  mi3_pkg::elem_type req_m10,
   input  mi3_pkg::elem_type req_m11,
   input  mi3_pkg::elem_type req_m12,
   input  mi3_pkg::elem_type req_m20,
   input  mi3_pkg::elem_type req_m21,
   input  mi3_pkg::elem_type req_m22,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mi3_pkg::res_type  rsp_r00,
   output mi3_pkg::res_type  rsp_r01,
   output mi3_pkg::res_type  rsp_r02,
   output mi3_pkg::res_type  rsp_r10,
   output mi3_pkg::res_type  rsp_r11,
   output mi3_pkg::res_type  rsp_r12,
   output mi3_pkg::res_type  rsp_r20,
   output mi3_pkg::res_type  rsp_r21,
   output mi3_pkg::res_type  rsp_r22,
   output logic              rsp_singular
);
   import mi3_pkg::*;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] v_prev;
   logic [NS-1:0] rdy;

   elem_type [NE-1:0] a_req;
   elem_type [NE-1:0] a0_ff, a1_ff, a2_ff, a3_ff, a4_ff;

   logic signed [PW-1:0] pp_in [2*NE];
   logic signed [PW-1:0] pp_ff [2*NE];
   logic signed [CW-1:0] cof_in [NE];
   logic signed [CW-1:0] cof_ff [NE];
   logic signed [CW-1:0] cof2_ff [NE];
   logic signed [CW-1:0] cof3_ff [NE];
   logic signed [TW-1:0] t_in [3];
   logic signed [TW-1:0] t_ff [3];
   logic signed [DW-1:0] det_in, det_ff;
   logic [DW-1:0]        dmag_in, dmag_ff;
   logic                 zero_in, zero_ff;
   logic [PW-1:0]        cmag_in [NE];
   logic [PW-1:0]        cmag_ff [NE];
   logic                 negq_in [NE];
   logic                 negq_ff [NE];

   div_type seed_in, seed_ff;
   div_type div_prev [OW];
   div_type div_in [OW];
   div_type div_ff [OW];

   res_type r_in [NE];
   res_type r_ff [NE];
   logic    sing_in, sing_ff;

   assign a_req = {req_m22, req_m21, req_m20, req_m12, req_m11, req_m10,
                   req_m02, req_m01, req_m00};

   assign v_prev = {v_ff[NS-2:0], req_valid};

   always_comb begin
      rdy[NS-1] = !v_ff[NS-1] || !rsp_stall;
      for (int i = NS - 2; i >= 0; i--) begin
         rdy[i] = !v_ff[i] || rdy[i+1];
      end
   end

   assign req_stall = !rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (rdy[i]) begin
               v_ff[i] <= v_prev[i];
            end
         end
      end
   end

   // Pair products of the nine 2x2 minors, two per cofactor.
   always_comb begin
      pp_in[0]  = $signed(a_req[4]) * $signed(a_req[8]);
      pp_in[1]  = $signed(a_req[5]) * $signed(a_req[7]);
      pp_in[2]  = $signed(a_req[6]) * $signed(a_req[5]);
      pp_in[3]  = $signed(a_req[3]) * $signed(a_req[8]);
      pp_in[4]  = $signed(a_req[3]) * $signed(a_req[7]);
      pp_in[5]  = $signed(a_req[6]) * $signed(a_req[4]);
      pp_in[6]  = $signed(a_req[2]) * $signed(a_req[7]);
      pp_in[7]  = $signed(a_req[1]) * $signed(a_req[8]);
      pp_in[8]  = $signed(a_req[0]) * $signed(a_req[8]);
      pp_in[9]  = $signed(a_req[6]) * $signed(a_req[2]);
      pp_in[10] = $signed(a_req[1]) * $signed(a_req[6]);
      pp_in[11] = $signed(a_req[0]) * $signed(a_req[7]);
      pp_in[12] = $signed(a_req[1]) * $signed(a_req[5]);
      pp_in[13] = $signed(a_req[4]) * $signed(a_req[2]);
      pp_in[14] = $signed(a_req[3]) * $signed(a_req[2]);
      pp_in[15] = $signed(a_req[0]) * $signed(a_req[5]);
      pp_in[16] = $signed(a_req[0]) * $signed(a_req[4]);
      pp_in[17] = $signed(a_req[3]) * $signed(a_req[1]);
   end

   // Each lane divides the cofactor of the transposed position.
   always_comb begin
      for (int n = 0; n < NE; n++) begin
         cof_in[n] = CW'(pp_ff[2*n]) - CW'(pp_ff[2*n+1]);
      end
      for (int i = 0; i < 3; i++) begin
         t_in[i] = $signed(a1_ff[i]) * cof_ff[i];
      end
      det_in  = DW'(t_ff[0]) + DW'(t_ff[1]) + DW'(t_ff[2]);
      dmag_in = det_ff[DW-1] ? DW'(-det_ff) : DW'(det_ff);
      zero_in = (det_ff == '0);
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            cmag_in[3*i+j] = cof3_ff[3*j+i][CW-1] ? PW'(-cof3_ff[3*j+i])
                                                  : PW'(cof3_ff[3*j+i]);
            negq_in[3*i+j] = cof3_ff[3*j+i][CW-1] ^ det_ff[DW-1];
         end
      end
   end

   // The quotient saturates when the magnitude reaches two to the output width.
   always_comb begin
      seed_in.dmag = dmag_ff;
      seed_in.zero = zero_ff;
      seed_in.a    = a4_ff;
      for (int n = 0; n < NE; n++) begin
         seed_in.lane[n].rem  = {cmag_ff[n], {SHIFT{1'b0}}};
         seed_in.lane[n].q    = '0;
         seed_in.lane[n].negq = negq_ff[n];
         seed_in.lane[n].ovf  = RW'({cmag_ff[n], {SHIFT{1'b0}}})
                                >= RW'({dmag_ff, {OW{1'b0}}});
      end
   end

   for (genvar j = 0; j < OW; j++) begin : g_div
      localparam int K = OW - 1 - j;
      if (j == 0) begin : g_first
         assign div_prev[j] = seed_ff;
      end else begin : g_next
         assign div_prev[j] = div_ff[j-1];
      end

      always_comb begin
         logic [RW-1:0] sub;
         div_in[j] = div_prev[j];
         sub = RW'(div_prev[j].dmag) << K;
         for (int n = 0; n < NE; n++) begin
            if (RW'(div_prev[j].lane[n].rem) >= sub) begin
               div_in[j].lane[n].rem  = div_prev[j].lane[n].rem - NW'(sub);
               div_in[j].lane[n].q[K] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[6+j]) begin
            div_ff[j] <= div_in[j];
         end
      end
   end

   always_comb begin
      logic [OW:0]            mag;
      logic signed [OW+1:0]   sv;
      div_type                last;
      last    = div_ff[OW-1];
      sing_in = last.zero;
      for (int n = 0; n < NE; n++) begin
         mag = last.lane[n].ovf ? {1'b1, {OW{1'b0}}} : {1'b0, last.lane[n].q};
         sv  = last.lane[n].negq ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
         if (last.zero) begin
            r_in[n] = $signed({{(OW-EW){last.a[n][EW-1]}}, last.a[n]}) <<< UP;
         end else if (sv > $signed({3'b000, {(OW-1){1'b1}}})) begin
            r_in[n] = {1'b0, {(OW-1){1'b1}}};
         end else if (sv < $signed({3'b111, {(OW-1){1'b0}}})) begin
            r_in[n] = {1'b1, {(OW-1){1'b0}}};
         end else begin
            r_in[n] = sv[OW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         a0_ff <= a_req;
         pp_ff <= pp_in;
      end
      if (rdy[1]) begin
         a1_ff  <= a0_ff;
         cof_ff <= cof_in;
      end
      if (rdy[2]) begin
         a2_ff   <= a1_ff;
         cof2_ff <= cof_ff;
         t_ff    <= t_in;
      end
      if (rdy[3]) begin
         a3_ff   <= a2_ff;
         cof3_ff <= cof2_ff;
      end
      if (rdy[4]) begin
         a4_ff   <= a3_ff;
         dmag_ff <= dmag_in;
         zero_ff <= zero_in;
         cmag_ff <= cmag_in;
         negq_ff <= negq_in;
      end
      if (rdy[5]) begin
         seed_ff <= seed_in;
      end
      if (rdy[NS-1]) begin
         r_ff    <= r_in;
         sing_ff <= sing_in;
      end
   end

   // The determinant is summed one stage after its three row terms.
   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         det_ff <= det_in;
      end
   end

   assign rsp_valid    = v_ff[NS-1];
   assign rsp_singular = sing_ff;
   assign rsp_r00      = r_ff[0];
   assign rsp_r01      = r_ff[1];
   assign rsp_r02      = r_ff[2];
   assign rsp_r10      = r_ff[3];
   assign rsp_r11      = r_ff[4];
   assign rsp_r12      = r_ff[5];
   assign rsp_r20      = r_ff[6];
   assign rsp_r21      = r_ff[7];
   assign rsp_r22      = r_ff[8];

   a_stall_busy : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v_ff[0] && rsp_valid && rsp_stall))
      else $error("input stalled with a free path to the output");

   a_out_hold : assert property (@(posedge clock) disable iff (reset)
      !rdy[NS-1] |=> (rsp_valid && $stable(rsp_r00) && $stable(rsp_singular)))
      else $error("output register changed while held");

   a_rem_bound : assert property (@(posedge clock) disable iff (reset)
      (v_ff[NS-2] && !div_ff[OW-1].zero && !div_ff[OW-1].lane[0].ovf)
      |-> (RW'(div_ff[OW-1].lane[0].rem) < RW'(div_ff[OW-1].dmag)))
      else $error("divider remainder not below the divisor");

   a_echo_frac : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_singular) |-> (rsp_r00[UP-1:0] == '0 && rsp_r22[UP-1:0] == '0))
      else $error("singular echo carries fraction bits");

endmodule
